@@ design/wtlg_pkg.sv @@
package wtlg_pkg;

  typedef enum logic [1:0] {
    MODE_AND  = 2'd0,
    MODE_OR   = 2'd1,
    MODE_XOR  = 2'd2,
    MODE_XNOR = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic REG_LOGIC_MODE     = 1'b0;
  localparam logic REG_WINDOW_SAMPLES = 1'b1;

  localparam int WINDOW_W = 16;

  typedef logic [WINDOW_W-1:0] window_t;

endpackage

@@ design/windowed_trigger_logic_gate.sv @@
// Windowed trigger logic gate.
// Input channel: in_valid/in_ready with trigger_a and trigger_b, one beat per sample.
// Output channel: out_valid/out_ready with trigger_out, the held output level
// after that sample; every input beat produces exactly one output beat.
// Configuration: write cfg_data to register cfg_index when cfg_write is high
// (0 = logic_mode, 1 = window_samples); write only while no beat is in flight.
// Latency: the result of an accepted beat is presented on the next cycle.
// Throughput: one beat per cycle while out_ready is high; the window counter,
// the awaited-input flag and the output level all update in the accept cycle,
// so a new sample can follow every cycle.
// Stall: when the receiver holds out_ready low, the result register keeps its
// beat and in_ready drops until that beat is taken; no beat is lost.
// Reset (rst, synchronous): mode and, window 0, window closed, awaiting a,
// output level off, no result pending.
module windowed_trigger_logic_gate (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        trigger_a,
  input  logic        trigger_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        trigger_out
);

  wtlg_pkg::mode_t   logic_mode;
  wtlg_pkg::window_t window_samples;

  wtlg_pkg::window_t window_count;
  wtlg_pkg::window_t window_count_next;
  logic              awaiting_b;
  logic              awaiting_b_next;
  logic              out_level;
  logic              out_level_next;

  logic              in_accept;
  logic              idle;
  logic              awaited;
  logic              last_count;
  wtlg_pkg::window_t count_dec;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign idle       = (window_count == '0);
  assign awaited    = awaiting_b ? trigger_b : trigger_a;
  assign count_dec  = window_count - wtlg_pkg::window_t'(1);
  assign last_count = (count_dec == '0);

  always_comb begin
    window_count_next = window_count;
    awaiting_b_next   = awaiting_b;
    out_level_next    = out_level;
    case (logic_mode)
      wtlg_pkg::MODE_AND: begin
        if (idle) begin
          if (trigger_a && trigger_b) begin
            out_level_next = 1'b1;
          end else begin
            out_level_next = 1'b0;
            if (trigger_a || trigger_b) begin
              window_count_next = window_samples;
              awaiting_b_next   = trigger_a;
            end
          end
        end else if (awaited) begin
          out_level_next    = 1'b1;
          window_count_next = '0;
        end else begin
          window_count_next = count_dec;
        end
      end
      wtlg_pkg::MODE_OR: begin
        if (idle) begin
          if (trigger_a || trigger_b) begin
            out_level_next    = 1'b1;
            window_count_next = window_samples;
          end else if (window_samples == '0) begin
            out_level_next = 1'b0;
          end
        end else begin
          window_count_next = count_dec;
          out_level_next    = 1'b0;
        end
      end
      wtlg_pkg::MODE_XOR: begin
        if (idle) begin
          if (trigger_a != trigger_b) begin
            if (window_samples == '0) begin
              out_level_next = 1'b1;
            end else begin
              window_count_next = window_samples;
              awaiting_b_next   = trigger_a;
            end
          end else begin
            out_level_next = 1'b0;
          end
        end else if (awaited) begin
          // cancel: the other input arrived inside the window
          window_count_next = '0;
        end else begin
          window_count_next = count_dec;
          if (last_count) begin
            out_level_next = 1'b1;
          end
        end
      end
      default: begin
        if (idle) begin
          if (trigger_a && !trigger_b) begin
            if (window_samples == '0) begin
              out_level_next = 1'b1;
            end else begin
              window_count_next = window_samples;
              awaiting_b_next   = 1'b1;
            end
          end else if (!trigger_a && trigger_b) begin
            window_count_next = window_samples;
            awaiting_b_next   = 1'b0;
          end else begin
            out_level_next = 1'b0;
          end
        end else if (trigger_b) begin
          window_count_next = '0;
        end else begin
          window_count_next = count_dec;
          if (last_count && awaiting_b) begin
            out_level_next = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      logic_mode     <= wtlg_pkg::MODE_AND;
      window_samples <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        wtlg_pkg::REG_LOGIC_MODE:     logic_mode     <= wtlg_pkg::mode_t'(cfg_data[1:0]);
        wtlg_pkg::REG_WINDOW_SAMPLES: window_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      awaiting_b   <= 1'b0;
      out_level    <= 1'b0;
    end else if (in_accept) begin
      window_count <= window_count_next;
      awaiting_b   <= awaiting_b_next;
      out_level    <= out_level_next;
    end
  end

  // Result register: hold the beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign trigger_out = out_level;

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_result_tracks_level: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (trigger_out == $past(out_level_next)))
    else $error("result does not match computed level");

  a_or_open_drops: assert property (@(posedge clk) disable iff (rst)
    (in_accept && logic_mode == wtlg_pkg::MODE_OR && !idle) |=> !trigger_out)
    else $error("or mode with open window did not drop output");

  a_and_both_on: assert property (@(posedge clk) disable iff (rst)
    (in_accept && logic_mode == wtlg_pkg::MODE_AND && idle && trigger_a && trigger_b)
      |=> (trigger_out && window_count == '0))
    else $error("and mode coincidence did not raise output");
`endif

endmodule
